>>> rtl/core/lmt_pkg.sv
package lmt_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 12;
    localparam int SLOT_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam int TOK_DEPTH = 4;
    localparam int TOK_PTR_W = 2;
    localparam int TOK_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } token_t;

    typedef struct packed {
        logic tail_pend;
        logic fifo_full;
    } sched_status_t;

endpackage

>>> rtl/core/lmt_line_mem.sv
module lmt_line_mem #(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW_DIM = 5,
    localparam int S = 2 * (WINDOW_DIM / 2) + 3,
    localparam int ADDR_W = $clog2(MAX_WIDTH),
    localparam int LANE_W = $clog2(S)
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [ADDR_W-1:0]               wr_addr,
    input  logic [LANE_W-1:0]               wr_lane,
    input  logic [lmt_pkg::PIX_W-1:0]       wr_data,
    input  logic                            rd_en,
    input  logic [ADDR_W-1:0]               rd_addr,
    output logic [S-1:0][lmt_pkg::PIX_W-1:0] rd_data
);
    import lmt_pkg::*;

    // one word per column, one byte lane per buffered row
    logic [S-1:0][PIX_W-1:0] mem [MAX_WIDTH];
    logic [S-1:0][PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr][wr_lane] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/lmt_sched.sv
module lmt_sched #(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW_DIM = 5,
    localparam int H = WINDOW_DIM / 2,
    localparam int S = 2 * H + 3,
    localparam int ADDR_W = $clog2(MAX_WIDTH),
    localparam int LANE_W = $clog2(S)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [lmt_pkg::PIX_W-1:0]         pixel_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lmt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              wr_en,
    output logic [ADDR_W-1:0]                 wr_addr,
    output logic [LANE_W-1:0]                 wr_lane,
    output logic [lmt_pkg::PIX_W-1:0]         wr_data,
    output logic                              tok_valid,
    output lmt_pkg::token_t                   tok,
    input  logic                              tok_pop,
    output logic [lmt_pkg::COL_W-1:0]         w_m1,
    output logic [lmt_pkg::ROW_W-1:0]         h_m1,
    output lmt_pkg::sched_status_t            status
);
    import lmt_pkg::*;

    localparam int WCAP = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4095;

    logic [11:0]          cfg_w_reg, cfg_w_next;
    logic [12:0]          cfg_h_reg, cfg_h_next;
    logic [COL_W-1:0]     in_col_reg, in_col_next;
    logic [ROW_W-1:0]     in_row_reg, in_row_next;
    logic [SLOT_W-1:0]    in_slot_reg, in_slot_next;
    logic                 in_done_reg, in_done_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [ROW_W-1:0]     out_row_reg, out_row_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic                 tail_reg, tail_next;
    token_t               tok_mem_reg [TOK_DEPTH];
    logic [TOK_PTR_W-1:0] wp_reg, wp_next;
    logic [TOK_PTR_W-1:0] rp_reg, rp_next;
    logic [TOK_CNT_W-1:0] cnt_reg, cnt_next;

    logic    acc;
    logic    is_pix;
    logic    push;
    logic    last;
    logic    hazard;
    token_t  head;
    token_t  new_tok;

    always_comb
    begin
        if (cfg_w_reg == 12'd0)
            w_m1 = '0;
        else if (int'(cfg_w_reg) > WCAP)
            w_m1 = COL_W'(WCAP - 1);
        else
            w_m1 = COL_W'(cfg_w_reg - 12'd1);
        if (cfg_h_reg == 13'd0)
            h_m1 = '0;
        else if (int'(cfg_h_reg) > MAX_HEIGHT)
            h_m1 = ROW_W'(MAX_HEIGHT - 1);
        else
            h_m1 = ROW_W'(cfg_h_reg - 13'd1);
    end

    assign head      = tok_mem_reg[rp_reg];
    assign tok       = head;
    assign tok_valid = (cnt_reg != '0);

    // hold items back while a queued item still needs rows a new pixel would overwrite,
    // and across a frame boundary until the old frame is fetched
    assign hazard   = tok_valid &&
                      (tail_reg || (({1'b0, head.row} + (ROW_W+1)'(H + 2)) <= {1'b0, in_row_reg}));
    assign in_stall = (cnt_reg == TOK_CNT_W'(TOK_DEPTH)) || hazard;
    assign cfg_ready = 1'b1;

    assign acc     = in_valid && !in_stall;
    assign is_pix  = acc && !func && !in_done_reg;
    assign wr_en   = is_pix;
    assign wr_addr = ADDR_W'(in_col_reg);
    assign wr_lane = in_slot_reg[LANE_W-1:0];
    assign wr_data = pixel_value;

    assign status.tail_pend = tail_reg;
    assign status.fifo_full = (cnt_reg == TOK_CNT_W'(TOK_DEPTH));

    always_comb
    begin
        logic [COL_W-1:0] ic1;
        logic [ROW_W-1:0] ir1;
        logic [SLOT_W-1:0] is1;
        logic             d1;
        logic [ROW_W:0]   nr;
        logic [COL_W:0]   nc;
        ic1 = in_col_reg;
        ir1 = in_row_reg;
        is1 = in_slot_reg;
        d1  = in_done_reg;
        if (is_pix)
        begin
            if (in_col_reg == w_m1)
            begin
                ic1 = '0;
                if (in_row_reg == h_m1)
                begin
                    ir1 = '0;
                    is1 = '0;
                    d1  = 1'b1;
                end
                else
                begin
                    ir1 = in_row_reg + 1'b1;
                    is1 = (in_slot_reg == SLOT_W'(S - 1)) ? '0 : in_slot_reg + 1'b1;
                end
            end
            else
            begin
                ic1 = in_col_reg + 1'b1;
            end
        end

        // bottom-right neighbor that must have arrived, clipped at the frame
        nr = {1'b0, out_row_reg} + (ROW_W+1)'(H);
        if (nr > {1'b0, h_m1})
            nr = {1'b0, h_m1};
        nc = {1'b0, out_col_reg} + (COL_W+1)'(H);
        if (nc > {1'b0, w_m1})
            nc = {1'b0, w_m1};

        push = acc && (d1 || ({1'b0, ir1} > nr) || (({1'b0, ir1} == nr) && ({1'b0, ic1} > nc)));
        last = (out_row_reg == h_m1) && (out_col_reg == w_m1);

        new_tok.row  = out_row_reg;
        new_tok.col  = out_col_reg;
        new_tok.slot = out_slot_reg;
        new_tok.last = last;

        in_col_next   = ic1;
        in_row_next   = ir1;
        in_slot_next  = is1;
        in_done_next  = d1;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        cfg_w_next    = cfg_w_reg;
        cfg_h_next    = cfg_h_reg;

        if (push)
        begin
            if (last)
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                in_slot_next  = '0;
                in_done_next  = 1'b0;
                out_col_next  = '0;
                out_row_next  = '0;
                out_slot_next = '0;
            end
            else if (out_col_reg == w_m1)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 1'b1;
                out_slot_next = (out_slot_reg == SLOT_W'(S - 1)) ? '0 : out_slot_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end

        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  cfg_w_next = cfg_data[11:0];
                REG_FRAME_HEIGHT: cfg_h_next = cfg_data;
                default: ;
            endcase
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            in_done_next  = 1'b0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
        end

        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = tok_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + TOK_CNT_W'(push) - TOK_CNT_W'(tok_pop);
        if (push && last)
            tail_next = 1'b1;
        else if (cnt_next == '0)
            tail_next = 1'b0;
        else
            tail_next = tail_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg    <= FRAME_WIDTH_RESET;
            cfg_h_reg    <= FRAME_HEIGHT_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            tail_reg     <= 1'b0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            cfg_w_reg    <= cfg_w_next;
            cfg_h_reg    <= cfg_h_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            in_done_reg  <= in_done_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            tail_reg     <= tail_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            tok_mem_reg[wp_reg] <= new_tok;
        end
    end

endmodule

>>> rtl/core/lmt_fetch.sv
module lmt_fetch #(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW_DIM = 5,
    localparam int H = WINDOW_DIM / 2,
    localparam int K = 2 * H + 1,
    localparam int S = 2 * H + 3,
    localparam int ADDR_W = $clog2(MAX_WIDTH),
    localparam int LANE_W = $clog2(S),
    localparam int J_W = $clog2(H + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  tok_valid,
    input  lmt_pkg::token_t                       tok,
    output logic                                  tok_pop,
    input  logic [lmt_pkg::COL_W-1:0]             w_m1,
    input  logic [lmt_pkg::ROW_W-1:0]             h_m1,
    output logic                                  rd_en,
    output logic [ADDR_W-1:0]                     rd_addr,
    input  logic [S-1:0][lmt_pkg::PIX_W-1:0]      rd_data,
    output logic [K*K-1:0][lmt_pkg::PIX_W-1:0]    win_val,
    output logic [K*K-1:0]                        win_vld,
    output logic                                  ev_valid,
    output logic                                  ev_last
);
    import lmt_pkg::*;

    logic [J_W-1:0]    j_reg, j_next;
    logic              s1_valid_reg;
    logic              s1_ok_reg;
    logic              s1_clear_reg;
    logic              s1_final_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_last_reg;
    logic              ev_valid_reg;
    logic              ev_last_reg;
    logic [PIX_W-1:0]  win_val_reg [K][K];
    logic              win_vld_reg [K][K];

    logic              row_start;
    logic [COL_W:0]    op_col;
    logic              op_final;
    logic              op_ok;
    logic [PIX_W-1:0]  new_val [K];
    logic              new_vld [K];

    // a row start loads columns 0..H into a cleared window, later items shift in one column
    assign row_start = (tok.col == '0);
    assign op_col    = row_start ? (COL_W+1)'(j_reg) : {1'b0, tok.col} + (COL_W+1)'(H);
    assign op_final  = !row_start || (j_reg == J_W'(H));
    assign op_ok     = (op_col <= {1'b0, w_m1});
    assign rd_en     = adv && tok_valid && op_ok;
    assign rd_addr   = ADDR_W'(op_col);
    assign tok_pop   = adv && tok_valid && op_final;

    always_comb
    begin
        j_next = j_reg;
        if (adv && tok_valid)
        begin
            j_next = op_final ? '0 : j_reg + 1'b1;
        end
    end

    always_comb
    begin
        logic [SLOT_W:0] base;
        logic [SLOT_W:0] lane;
        logic [ROW_W:0]  rk;
        base = {1'b0, s1_slot_reg} + (SLOT_W+1)'(S - H);
        if (base >= (SLOT_W+1)'(S))
            base = base - (SLOT_W+1)'(S);
        for (int k = 0; k < K; k++)
        begin
            lane = base + (SLOT_W+1)'(k);
            if (lane >= (SLOT_W+1)'(S))
                lane = lane - (SLOT_W+1)'(S);
            rk = {1'b0, s1_row_reg} + (ROW_W+1)'(k);
            new_val[k] = rd_data[lane[LANE_W-1:0]];
            // row k of the column is row - H + k, clipped to the frame
            new_vld[k] = s1_ok_reg && (rk >= (ROW_W+1)'(H)) &&
                         (rk <= ({1'b0, h_m1} + (ROW_W+1)'(H)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg        <= '0;
            s1_valid_reg <= 1'b0;
            ev_valid_reg <= 1'b0;
            for (int c = 0; c < K; c++)
            begin
                for (int k = 0; k < K; k++)
                begin
                    win_vld_reg[c][k] <= 1'b0;
                end
            end
        end
        else
        begin
            j_reg <= j_next;
            if (adv)
            begin
                s1_valid_reg <= tok_valid;
                ev_valid_reg <= s1_valid_reg && s1_final_reg;
                if (s1_valid_reg)
                begin
                    for (int c = 0; c < K - 1; c++)
                    begin
                        for (int k = 0; k < K; k++)
                        begin
                            win_vld_reg[c][k] <= s1_clear_reg ? 1'b0 : win_vld_reg[c+1][k];
                        end
                    end
                    for (int k = 0; k < K; k++)
                    begin
                        win_vld_reg[K-1][k] <= new_vld[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ok_reg    <= op_ok;
            s1_clear_reg <= row_start && (j_reg == '0);
            s1_final_reg <= op_final;
            s1_row_reg   <= tok.row;
            s1_slot_reg  <= tok.slot;
            s1_last_reg  <= tok.last;
            ev_last_reg  <= s1_last_reg;
            if (s1_valid_reg)
            begin
                for (int c = 0; c < K - 1; c++)
                begin
                    for (int k = 0; k < K; k++)
                    begin
                        win_val_reg[c][k] <= win_val_reg[c+1][k];
                    end
                end
                for (int k = 0; k < K; k++)
                begin
                    win_val_reg[K-1][k] <= new_val[k];
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < K; c++)
        begin
            for (int k = 0; k < K; k++)
            begin
                win_val[c*K + k] = win_val_reg[c][k];
                win_vld[c*K + k] = win_vld_reg[c][k];
            end
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev_last  = ev_last_reg;

endmodule

>>> rtl/core/lmt_rank.sv
module lmt_rank #(
    parameter int WINDOW_DIM = 5,
    localparam int H = WINDOW_DIM / 2,
    localparam int K = 2 * H + 1,
    localparam int N = K * K
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ev_valid,
    input  logic                                ev_last,
    input  logic [N-1:0][lmt_pkg::PIX_W-1:0]    win_val,
    input  logic [N-1:0]                        win_vld,
    output logic                                adv,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lmt_pkg::PIX_W-1:0]           out_value,
    output logic                                out_last
);
    import lmt_pkg::*;

    localparam int R_W = $clog2(N + 1);
    localparam int CTR = H * K + H;

    logic                    a_valid_reg;
    logic                    a_last_reg;
    logic [N-1:0][PIX_W-1:0] a_val_reg;
    logic [N-1:0]            a_vld_reg;
    logic [N-1:0]            a_bef_reg [N];
    logic                    b_valid_reg;
    logic                    b_last_reg;
    logic [N-1:0][PIX_W-1:0] b_val_reg;
    logic [N-1:0]            b_vld_reg;
    logic [R_W-1:0]          b_rank_reg [N];
    logic [R_W-1:0]          b_half_reg;
    logic                    out_valid_reg;
    logic                    out_last_reg;
    logic [PIX_W-1:0]        out_value_reg;

    logic [N-1:0]            bef [N];
    logic [PIX_W-1:0]        med;
    logic [PIX_W-1:0]        ctr;

    assign adv = !out_valid_reg || !out_stall;

    // element j sorts before element i; index breaks ties
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
            begin
                bef[i][j] = win_vld[j] && ((win_val[j] < win_val[i]) ||
                            ((win_val[j] == win_val[i]) && (j < i)));
            end
        end
    end

    always_comb
    begin
        med = '0;
        for (int i = 0; i < N; i++)
        begin
            if (b_vld_reg[i] && (b_rank_reg[i] == b_half_reg))
                med = med | b_val_reg[i];
        end
        ctr = b_val_reg[CTR];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= ev_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_last_reg <= ev_last;
            a_val_reg  <= win_val;
            a_vld_reg  <= win_vld;
            for (int i = 0; i < N; i++)
            begin
                a_bef_reg[i]  <= bef[i];
                b_rank_reg[i] <= R_W'($countones(a_bef_reg[i]));
            end
            b_last_reg    <= a_last_reg;
            b_val_reg     <= a_val_reg;
            b_vld_reg     <= a_vld_reg;
            b_half_reg    <= R_W'($countones(a_vld_reg)) >> 1;
            out_last_reg  <= b_last_reg;
            out_value_reg <= (ctr < med) ? '0 : ctr;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

>>> rtl/core/local_median_threshold_unit.sv
// Local median threshold over a square neighborhood, clipped at the frame edges.
// in channel (in_valid / in_stall): func = 0 carries the next raster pixel in pixel_value,
// func = 1 is a drain item that releases one pending result. Each item releases at most one
// result, in raster order, once every pixel of its neighborhood has arrived.
// out channel (out_valid / out_stall): out_value is 0 below the local median, else the pixel;
// out_last marks the final pixel of the frame.
// cfg channel (cfg_valid / cfg_ready, always ready): cfg_index 0 = frame width, 1 = height.
// Any write restarts the frame. Write only while the block is idle.
// The result path runs through the result queue, the line memory read, the window registers
// and the rank stages a, b and out; the first result of a row waits longer, since the window
// reloads columns 0..WINDOW_DIM/2 from the line memory through its single read port.
// Throughput: one item per cycle while in_stall is low; a row of W results needs
// W + WINDOW_DIM/2 line memory read steps, as each row start reloads columns 0..WINDOW_DIM/2.
// in_stall also rises at a frame boundary until the old frame is fetched.
// Reset: positions cleared, frame 640 x 480; line memory contents are not cleared.
// A stalled out channel freezes the result pipeline; input keeps flowing until the 4-entry
// result queue fills.
module local_median_threshold_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int WINDOW_DIM = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [lmt_pkg::PIX_W-1:0]         pixel_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lmt_pkg::PIX_W-1:0]         out_value,
    output logic                              out_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lmt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lmt_pkg::*;

    localparam int H = WINDOW_DIM / 2;
    localparam int K = 2 * H + 1;
    localparam int S = 2 * H + 3;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int LANE_W = $clog2(S);

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [LANE_W-1:0]       wr_lane;
    logic [PIX_W-1:0]        wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [S-1:0][PIX_W-1:0] rd_data;
    logic                    tok_valid;
    token_t                  tok;
    logic                    tok_pop;
    logic [COL_W-1:0]        w_m1;
    logic [ROW_W-1:0]        h_m1;
    sched_status_t           status;
    logic                    adv;
    logic [K*K-1:0][PIX_W-1:0] win_val;
    logic [K*K-1:0]          win_vld;
    logic                    ev_valid;
    logic                    ev_last;

    lmt_sched #(
        .MAX_WIDTH  (MAX_WIDTH),
        .WINDOW_DIM (WINDOW_DIM)
    ) u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .pixel_value (pixel_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_lane     (wr_lane),
        .wr_data     (wr_data),
        .tok_valid   (tok_valid),
        .tok         (tok),
        .tok_pop     (tok_pop),
        .w_m1        (w_m1),
        .h_m1        (h_m1),
        .status      (status)
    );

    lmt_line_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .WINDOW_DIM (WINDOW_DIM)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_lane (wr_lane),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lmt_fetch #(
        .MAX_WIDTH  (MAX_WIDTH),
        .WINDOW_DIM (WINDOW_DIM)
    ) u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .w_m1      (w_m1),
        .h_m1      (h_m1),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .win_val   (win_val),
        .win_vld   (win_vld),
        .ev_valid  (ev_valid),
        .ev_last   (ev_last)
    );

    lmt_rank #(
        .WINDOW_DIM (WINDOW_DIM)
    ) u_rank (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_last   (ev_last),
        .win_val   (win_val),
        .win_vld   (win_vld),
        .adv       (adv),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (out_value),
        .out_last  (out_last)
    );

    // the fetch side only retires queued items that exist
    ast_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        tok_pop |-> tok_valid)
        else $error("item popped from an empty result queue");

    // no item taken while the queue is full
    ast_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !status.fifo_full)
        else $error("item accepted with a full result queue");

    // a new frame must not overwrite line rows the old frame still needs
    ast_frame_fence: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !status.tail_pend)
        else $error("item accepted before the previous frame was fetched");

    // no line memory read is issued while the pipeline is held back
    ast_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> !rd_en)
        else $error("line memory read issued while the pipeline is frozen");

endmodule
